// ===== rtl/core/rsfl_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfl_pkg
// Shared sizes, codes and control bundles of the record slot free list.
// ----------------------------------------------------------------------------
package rsfl_pkg;

	localparam int DEPTH       = 256;
	localparam int RECORD_BITS = 64;

	localparam int SLOT_W   = 9;
	localparam int DATA_W   = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	// links, head and slot count hold 0 .. DEPTH+1
	localparam int LINK_W   = $clog2(DEPTH + 2);
	localparam int CMP_W    = (LINK_W > SLOT_W) ? LINK_W : SLOT_W;

	localparam logic [LINK_W-1:0] LIST_END  = LINK_W'(DEPTH + 1);
	localparam logic [LINK_W-1:0] LINK_LIVE = '0;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DELETED = 2'd1,
		ST_RANGE   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] wr_idx;
		logic             link_we;
		logic             rec_we;
	} mem_ctl_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_used;
		logic [DATA_W-1:0] record_out;
	} result_t;

endpackage

// ===== rtl/core/rsfl_ram.sv =====
// ----------------------------------------------------------------------------
// rsfl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/rsfl_seq.sv =====
// ----------------------------------------------------------------------------
// rsfl_seq
// Two-step sequencer: issue memory reads on accept, then check, answer and
// write back the link and record memories together with head and count.
// ----------------------------------------------------------------------------
module rsfl_seq
	import rsfl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             opcode,
	input  logic [SLOT_W-1:0]      slot,
	input  logic [DATA_W-1:0]      record_data,
	output mem_ctl_t               mem,
	output logic [LINK_W-1:0]      link_wdata,
	output logic [RECORD_BITS-1:0] rec_wdata,
	input  logic [LINK_W-1:0]      link_rdata,
	input  logic [RECORD_BITS-1:0] rec_rdata,
	output logic                   res_valid,
	input  logic                   res_ready,
	output result_t                res
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                 state_q;
	logic [LINK_W-1:0]      free_head_q;
	logic [LINK_W-1:0]      count_q;
	op_t                    op_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [RECORD_BITS-1:0] data_q;

	logic              accept;
	logic [CMP_W-1:0]  slot_c, head_c, count_c;
	logic              slot_ok, head_ok;
	logic [LINK_W-1:0] head_nxt, count_nxt;
	logic              do_write;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign res_valid = (state_q == S_EXEC);
	assign do_write = res_valid && res_ready;

	assign slot_c  = CMP_W'(slot);
	assign head_c  = CMP_W'(free_head_q);
	assign count_c = CMP_W'(count_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(opcode);
			slot_q <= slot;
			data_q <= record_data[RECORD_BITS-1:0];
		end
	end

	// read side issued with the accepted beat, execute step uses the read data
	always_comb begin
		logic [CMP_W-1:0] s_c;
		s_c = CMP_W'(slot_q);
		mem.rd_en = accept;
		if (op_t'(opcode) == OP_ADD) begin
			mem.rd_idx = IDX_W'(head_c - CMP_W'(1));
		end else begin
			mem.rd_idx = IDX_W'(slot_c - CMP_W'(1));
		end

		slot_ok = (s_c != '0) && (s_c <= count_c);
		head_ok = (head_c != '0) && (head_c <= count_c);

		res.status     = ST_OK;
		res.slot_used  = slot_q;
		res.record_out = '0;
		head_nxt       = free_head_q;
		count_nxt      = count_q;
		mem.wr_idx     = IDX_W'(s_c - CMP_W'(1));
		mem.link_we    = 1'b0;
		mem.rec_we     = 1'b0;
		link_wdata     = LINK_LIVE;
		rec_wdata      = data_q;

		case (op_q)
			OP_ADD: begin
				if (head_ok) begin
					head_nxt      = link_rdata;
					mem.wr_idx    = IDX_W'(head_c - CMP_W'(1));
					mem.link_we   = do_write;
					mem.rec_we    = do_write;
					res.slot_used = SLOT_W'(head_c);
				end else if (count_q < LINK_W'(DEPTH)) begin
					// append past the high-water mark
					count_nxt     = count_q + LINK_W'(1);
					mem.wr_idx    = IDX_W'(count_q);
					mem.link_we   = do_write;
					mem.rec_we    = do_write;
					res.slot_used = SLOT_W'(count_c + CMP_W'(1));
				end else begin
					res.status    = ST_FULL;
					res.slot_used = '0;
				end
			end
			OP_DELETE: begin
				if (!slot_ok) begin
					res.status = ST_RANGE;
				end else if (link_rdata != LINK_LIVE) begin
					res.status = ST_DELETED;
				end else begin
					link_wdata  = free_head_q;
					mem.link_we = do_write;
					head_nxt    = LINK_W'(s_c);
				end
			end
			OP_READ: begin
				if (!slot_ok) begin
					res.status = ST_RANGE;
				end else if (link_rdata != LINK_LIVE) begin
					res.status = ST_DELETED;
				end else begin
					res.record_out = DATA_W'(rec_rdata);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= LIST_END;
			count_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (res_ready) begin
						free_head_q <= head_nxt;
						count_q     <= count_nxt;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == LIST_END) || ((free_head_q != '0) && (free_head_q <= count_q)))
		else $error("free list head outside the used slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LINK_W'(DEPTH))
		else $error("slot count past depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((count_q == $past(count_q)) ||
			((count_q == $past(count_q) + LINK_W'(1)) && ($past(state_q) == S_EXEC))))
		else $error("slot count moved by more than one append");

	a_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(mem.link_we || mem.rec_we) |-> (state_q == S_EXEC && res_ready))
		else $error("memory write outside the execute step");

	a_rec_with_link: assert property (@(posedge clk) disable iff (!arst_n)
		mem.rec_we |-> (mem.link_we && link_wdata == LINK_LIVE))
		else $error("record written without marking the slot live");

endmodule

// ===== rtl/core/record_slot_free_list.sv =====
// ----------------------------------------------------------------------------
// record_slot_free_list
// Fixed-size record slots with a last-in-first-out list of deleted slots.
// ----------------------------------------------------------------------------
// Each beat runs in two steps: in the accept cycle the link and record memories
// are read into registered read data; in the execute step the entry is checked,
// the result is loaded into the output register and the link and record
// memories are written back. The next input beat is taken in the cycle after
// the execute step, so a new beat is not accepted before the last one is done.
// The output register holds one finished result; the execute step waits only
// while that register is still full. Both memories come out of reset unwritten
// and need no clearing pass: read data is used only for slots already written.
// ----------------------------------------------------------------------------
module record_slot_free_list
	import rsfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [SLOT_W-1:0] slot,
	input  logic [DATA_W-1:0] record_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot_used,
	output logic [DATA_W-1:0] record_out
);

	mem_ctl_t               mem;
	logic [LINK_W-1:0]      link_wdata, link_rdata;
	logic [RECORD_BITS-1:0] rec_wdata, rec_rdata;
	logic                   res_valid, res_ready;
	result_t                res;
	logic                   out_valid_q;
	result_t                out_q;

	rsfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (mem.link_we),
		.waddr(mem.wr_idx),
		.wdata(link_wdata),
		.re   (mem.rd_en),
		.raddr(mem.rd_idx),
		.rdata(link_rdata)
	);

	rsfl_ram #(
		.WIDTH(RECORD_BITS),
		.DEPTH(DEPTH)
	) u_rec_ram (
		.clk  (clk),
		.we   (mem.rec_we),
		.waddr(mem.wr_idx),
		.wdata(rec_wdata),
		.re   (mem.rd_en),
		.raddr(mem.rd_idx),
		.rdata(rec_rdata)
	);

	rsfl_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.slot       (slot),
		.record_data(record_data),
		.mem        (mem),
		.link_wdata (link_wdata),
		.rec_wdata  (rec_wdata),
		.link_rdata (link_rdata),
		.rec_rdata  (rec_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign slot_used  = out_q.slot_used;
	assign record_out = out_q.record_out;

endmodule

// ===== tb/slot_reply_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_reply_checker
// Watches both channels of the record slot free list. It keeps its own copy
// of the slot store and free list, works out the reply to every accepted
// request beat, and compares each reply beat with the oldest one waiting.
// ----------------------------------------------------------------------------
module slot_reply_checker
	import rsfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [SLOT_W-1:0] slot,
	input  logic [DATA_W-1:0] record_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        status,
	input  logic [SLOT_W-1:0] slot_used,
	input  logic [DATA_W-1:0] record_out,
	output int                errors,
	output int                outstanding
);

	localparam logic [DATA_W-1:0] DATA_MASK = {DATA_W{1'b1}} >> (DATA_W - RECORD_BITS);

	logic [DATA_W-1:0] shadow_data [1:DEPTH];
	logic [LINK_W-1:0] shadow_link [1:DEPTH];
	logic [LINK_W-1:0] shadow_head;
	int unsigned       shadow_used;
	result_t           pending_replies [$];
	int                mismatch_count;

	function automatic bit live_range(int unsigned s);
		return s >= 1 && s <= shadow_used && s <= DEPTH;
	endfunction

	task automatic predict_reply(
		input  logic [1:0]        op_bits,
		input  logic [SLOT_W-1:0] s,
		input  logic [DATA_W-1:0] d,
		output result_t           r
	);
		int unsigned h;
		op_t         op;
		op = op_t'(op_bits);
		r.status     = ST_OK;
		r.slot_used  = s;
		r.record_out = '0;
		case (op)
			OP_ADD: begin
				if (live_range(shadow_head)) begin
					// reuse the most recently deleted slot
					h = shadow_head;
					shadow_head    = shadow_link[h];
					shadow_data[h] = d & DATA_MASK;
					shadow_link[h] = LINK_LIVE;
					r.slot_used    = SLOT_W'(h);
				end else if (shadow_used < DEPTH) begin
					shadow_used++;
					shadow_data[shadow_used] = d & DATA_MASK;
					shadow_link[shadow_used] = LINK_LIVE;
					r.slot_used = SLOT_W'(shadow_used);
				end else begin
					r.status    = ST_FULL;
					r.slot_used = '0;
				end
			end
			OP_DELETE: begin
				if (!live_range(s)) begin
					r.status = ST_RANGE;
				end else if (shadow_link[s] != LINK_LIVE) begin
					r.status = ST_DELETED;
				end else begin
					shadow_link[s] = shadow_head;
					shadow_head    = LINK_W'(s);
				end
			end
			OP_READ: begin
				if (!live_range(s)) begin
					r.status = ST_RANGE;
				end else if (shadow_link[s] != LINK_LIVE) begin
					r.status = ST_DELETED;
				end else begin
					r.record_out = shadow_data[s] & DATA_MASK;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic void note_mismatch(string field, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		mismatch_count++;
		$display("%0t: %s expected %0h got %0h", $time, field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			shadow_head    = LIST_END;
			shadow_used    = 0;
			mismatch_count = 0;
			pending_replies.delete();
			errors      <= 0;
			outstanding <= 0;
		end else begin
			// reply beats are checked before this edge's request is queued
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					mismatch_count++;
					$display("%0t: expected no beat, got status %0d slot %0d data %0h",
						$time, status, slot_used, record_out);
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status)
						note_mismatch("status", DATA_W'(want.status), DATA_W'(status));
					if (slot_used !== want.slot_used)
						note_mismatch("slot_used", DATA_W'(want.slot_used), DATA_W'(slot_used));
					if (record_out !== want.record_out)
						note_mismatch("record_out", want.record_out, record_out);
				end
			end
			if (in_valid && in_ready) begin
				predict_reply(opcode, slot, record_data, fresh);
				pending_replies.insert(pending_replies.size(), fresh);
			end
			errors      <= mismatch_count;
			outstanding <= pending_replies.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, delete, read and idle requests into the record slot free list
// with random gaps and reply stalls: a directed opening, a small store with
// churn, a fill past full, mixed traffic and a long free-list sweep. The
// checker beside the block predicts and compares every reply beat.
// ----------------------------------------------------------------------------
module testbench;
	import rsfl_pkg::*;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic [1:0]        opcode      = OP_NOP;
	logic [SLOT_W-1:0] slot        = '0;
	logic [DATA_W-1:0] record_data = '0;
	logic              out_ready   = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot_used;
	logic [DATA_W-1:0] record_out;
	int                errors;
	int                outstanding;
	// no gaps and no stalls while set
	bit                calm = 1'b0;

	record_slot_free_list dut (.*);

	slot_reply_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot(int hi);
		if ($urandom_range(0, 99) < 85)
			return SLOT_W'($urandom_range(1, hi));
		return SLOT_W'($urandom_range(0, 511));
	endfunction

	function automatic op_t pick_op(int add_pct);
		int r;
		int rest;
		r    = $urandom_range(0, 99);
		rest = 100 - add_pct - 5;
		if (r < add_pct)
			return OP_ADD;
		if (r < add_pct + rest / 2)
			return OP_DELETE;
		if (r < 95)
			return OP_READ;
		return OP_NOP;
	endfunction

	task automatic send_op(op_t op, logic [SLOT_W-1:0] s, logic [DATA_W-1:0] d);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		slot        <= s;
		record_data <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_burst(int count, int add_pct, int hi);
		repeat (count) send_op(pick_op(add_pct), pick_slot(hi), pick_data());
	endtask

	// reply side: a fresh random stall, possibly none, before every beat
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: nothing is in range yet
		send_op(OP_READ, 9'd1, '0);
		send_op(OP_DELETE, 9'd0, '0);
		send_op(OP_NOP, '1, '1);
		// add ignores the slot field
		send_op(OP_ADD, 9'd300, '1);
		send_op(OP_ADD, '0, '0);
		send_op(OP_ADD, '1, 64'h0123_4567_89ab_cdef);
		send_op(OP_READ, 9'd1, '0);
		send_op(OP_READ, 9'd2, '1);
		send_op(OP_READ, 9'd3, '0);
		send_op(OP_READ, 9'd4, '0);
		send_op(OP_READ, '1, '0);
		send_op(OP_DELETE, 9'd2, '0);
		send_op(OP_DELETE, 9'd2, '0);
		send_op(OP_READ, 9'd2, '0);
		send_op(OP_DELETE, 9'd1, '0);
		send_op(OP_DELETE, 9'd4, '0);
		// free list pops last deleted first, then appends
		send_op(OP_ADD, '0, 64'hfedc_ba98_7654_3210);
		send_op(OP_ADD, '0, 64'h8000_0000_0000_0001);
		send_op(OP_ADD, '0, 64'h5555_aaaa_5555_aaaa);
		send_op(OP_READ, 9'd1, '0);
		send_op(OP_READ, 9'd4, '0);
		send_op(OP_NOP, '0, '0);
		drain();

		// small store with churn, plenty of past-end slots
		random_burst(150, 40, 40);

		// fill the store and keep adding past full
		calm = 1'b1;
		repeat (300) send_op(OP_ADD, SLOT_W'($urandom_range(0, 511)), pick_data());
		calm = 1'b0;
		send_op(OP_READ, 9'd256, '0);
		send_op(OP_DELETE, 9'd257, '0);
		send_op(OP_DELETE, 9'd256, '0);
		send_op(OP_READ, 9'd256, '0);
		send_op(OP_ADD, '0, '1);
		send_op(OP_ADD, '0, '1);
		send_op(OP_READ, '1, '0);
		drain();

		for (int k = 0; k < 10; k++) begin
			calm = ($urandom_range(0, 3) == 0);
			random_burst(100, 30, DEPTH);
		end
		calm = 1'b0;

		// long free list, then refill it
		repeat (120) send_op(OP_DELETE, SLOT_W'($urandom_range(1, DEPTH)), pick_data());
		repeat (130) send_op(OP_ADD, pick_slot(DEPTH), pick_data());
		random_burst(60, 20, DEPTH);
		drain();

		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rsfl_pkg.sv
rtl/core/rsfl_ram.sv
rtl/core/rsfl_seq.sv
rtl/core/record_slot_free_list.sv
tb/slot_reply_checker.sv
tb/testbench.sv
